>>> hdl/rmfb_pkg.sv
// Package for the rotated monochrome frame store.
// Holds the request and command codes, the state encodings and the command type.
// It has no dependencies. All files but rmfb_ram and rmfb_checker import it.
package rmfb_pkg;

    localparam int COORD_W = 12;
    localparam int IDX_W   = 16;
    localparam int ADDR_W  = 21;
    localparam int PROD_W  = 24;
    localparam int BYTE_W  = 8;

    localparam logic [BYTE_W-1:0] BYTE_BLACK = 8'hFF;
    localparam logic [BYTE_W-1:0] BYTE_WHITE = 8'h00;
    localparam logic [BYTE_W-1:0] MSB_MASK   = 8'h80;

    typedef enum logic [1:0] {
        REQ_DRAW = 2'd0,
        REQ_FILL = 2'd1,
        REQ_READ = 2'd2
    } t_req_type;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } t_rotation;

    typedef enum logic [2:0] {
        K_DRAW,
        K_FILL,
        K_READ,
        K_DROP,
        K_NONE
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [ADDR_W-1:0] addr;
        logic [2:0]        bitpos;
        logic              white;
    } t_cmd;

    typedef enum logic {
        F_IDLE,
        F_MAP
    } t_fstate;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MOD,
        B_FILL,
        B_DONE
    } t_bstate;

endpackage

>>> hdl/rmfb_req_if.sv
// Request channel of the rotated monochrome frame store.
// Carries valid, ready and one request. Depends on rmfb_pkg.
interface rmfb_req_if import rmfb_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [1:0]                req_type;
    logic signed [COORD_W-1:0] pixel_x;
    logic signed [COORD_W-1:0] pixel_y;
    logic                      pixel_white;
    logic [IDX_W-1:0]          byte_index;

    modport source (
        output valid, req_type, pixel_x, pixel_y, pixel_white, byte_index,
        input  ready
    );
    modport sink (
        input  valid, req_type, pixel_x, pixel_y, pixel_white, byte_index,
        output ready
    );
endinterface

>>> hdl/rmfb_rsp_if.sv
// Result channel of the rotated monochrome frame store.
// Carries valid, ready and one result. Depends on rmfb_pkg.
interface rmfb_rsp_if import rmfb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_data;
    logic              dropped;

    modport source (
        output valid, read_data, dropped,
        input  ready
    );
    modport sink (
        input  valid, read_data, dropped,
        output ready
    );
endinterface

>>> hdl/rmfb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Has no dependencies.
module rmfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 48000
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> hdl/rmfb_fifo.sv
// Two-entry command queue between the front and back parts of the frame store.
// Depends on rmfb_pkg for the command type.
module rmfb_fifo import rmfb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);
    t_cmd       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       n_wptr;
    logic       n_rptr;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_cmd   = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = ~r_wptr;
        end
        if (i_pop) begin
            n_rptr = ~r_rptr;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end
endmodule

>>> hdl/rmfb_front.sv
// Front part of the frame store: accepts requests, checks bounds, rotates
// coordinates and computes the byte address. Depends on rmfb_pkg and rmfb_req_if.
module rmfb_front import rmfb_pkg::*; #(
    parameter int PANEL_WIDTH  = 800,
    parameter int PANEL_HEIGHT = 480
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rmfb_req_if.sink      i_req,
    input  logic [1:0]    i_rotation,
    input  logic          i_full,
    output logic          o_push,
    output t_cmd          o_cmd
);
    localparam int STORE_BYTES = (PANEL_WIDTH * PANEL_HEIGHT + 7) / 8;
    localparam logic [ADDR_W:0]      STORE_LIM = (ADDR_W + 1)'(STORE_BYTES);
    localparam logic [COORD_W:0]     LIM_W     = (COORD_W + 1)'(PANEL_WIDTH);
    localparam logic [COORD_W:0]     LIM_H     = (COORD_W + 1)'(PANEL_HEIGHT);
    localparam logic [COORD_W-1:0]   LAST_X    = COORD_W'(PANEL_WIDTH - 1);
    localparam logic [COORD_W-1:0]   LAST_Y    = COORD_W'(PANEL_HEIGHT - 1);

    t_fstate            r_state;
    t_fstate            n_state;
    t_kind              r_kind;
    logic [COORD_W-1:0] r_px;
    logic [COORD_W-1:0] r_py;
    logic               r_white;
    logic [IDX_W-1:0]   r_idx;

    t_kind              cls_kind;
    logic [COORD_W-1:0] map_px;
    logic [COORD_W-1:0] map_py;
    logic [COORD_W:0]   lim_x;
    logic [COORD_W:0]   lim_y;
    logic [COORD_W-1:0] ux;
    logic [COORD_W-1:0] uy;
    logic               x_ok;
    logic               y_ok;
    logic [PROD_W-1:0]  prod;
    logic [ADDR_W:0]    addr_sum;
    logic               accept;

    assign i_req.ready = (r_state == F_IDLE);
    assign accept      = i_req.valid && (r_state == F_IDLE);

    always_comb begin
        lim_x = i_rotation[0] ? LIM_H : LIM_W;
        lim_y = i_rotation[0] ? LIM_W : LIM_H;
        ux    = i_req.pixel_x;
        uy    = i_req.pixel_y;
        x_ok  = !ux[COORD_W-1] && ({1'b0, ux} < lim_x);
        y_ok  = !uy[COORD_W-1] && ({1'b0, uy} < lim_y);

        case (i_rotation)
            ROT_90: begin
                map_px = LAST_X - uy;
                map_py = ux;
            end
            ROT_180: begin
                map_px = LAST_X - ux;
                map_py = LAST_Y - uy;
            end
            ROT_270: begin
                map_px = uy;
                map_py = LAST_Y - ux;
            end
            default: begin
                map_px = ux;
                map_py = uy;
            end
        endcase

        case (i_req.req_type)
            REQ_DRAW: cls_kind = (x_ok && y_ok) ? K_DRAW : K_DROP;
            REQ_FILL: cls_kind = K_FILL;
            REQ_READ: begin
                cls_kind = ((ADDR_W + 1)'(i_req.byte_index) < STORE_LIM) ? K_READ : K_NONE;
            end
            default:  cls_kind = K_NONE;
        endcase
    end

    always_comb begin
        prod     = PROD_W'(r_py) * PROD_W'(PANEL_WIDTH);
        addr_sum = (ADDR_W + 1)'(r_px >> 3) + (ADDR_W + 1)'(prod >> 3);

        o_cmd.kind   = r_kind;
        o_cmd.addr   = addr_sum[ADDR_W-1:0];
        o_cmd.bitpos = r_px[2:0];
        o_cmd.white  = r_white;
        if (r_kind == K_DRAW && addr_sum >= STORE_LIM) begin
            o_cmd.kind = K_DROP;
        end
        if (r_kind == K_READ) begin
            o_cmd.addr = ADDR_W'(r_idx);
        end
    end

    always_comb begin
        n_state = r_state;
        o_push  = 1'b0;
        case (r_state)
            F_IDLE: begin
                if (i_req.valid) begin
                    n_state = F_MAP;
                end
            end
            F_MAP: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= cls_kind;
            r_px    <= map_px;
            r_py    <= map_py;
            r_white <= i_req.pixel_white;
            r_idx   <= i_req.byte_index;
        end
    end
endmodule

>>> hdl/rmfb_back.sv
// Back part of the frame store: executes queued commands against the byte
// memory and holds the result register. Depends on rmfb_pkg, rmfb_rsp_if, rmfb_ram.
module rmfb_back import rmfb_pkg::*; #(
    parameter int PANEL_WIDTH  = 800,
    parameter int PANEL_HEIGHT = 480
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  t_cmd          i_cmd,
    output logic          o_pop,
    rmfb_rsp_if.source    o_rsp
);
    localparam int STORE_BYTES = (PANEL_WIDTH * PANEL_HEIGHT + 7) / 8;
    localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);

    t_bstate           r_state;
    t_bstate           n_state;
    t_cmd              r_cmd;
    t_cmd              n_cmd;
    logic [AW-1:0]     r_fill_addr;
    logic [AW-1:0]     n_fill_addr;
    logic [BYTE_W-1:0] r_res_data;
    logic [BYTE_W-1:0] n_res_data;
    logic              r_res_drop;
    logic              n_res_drop;
    logic              r_ovalid;
    logic              n_ovalid;
    logic [BYTE_W-1:0] r_odata;
    logic              r_odrop;
    logic              out_load;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;
    logic [BYTE_W-1:0] bit_mask;

    rmfb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign bit_mask = MSB_MASK >> r_cmd.bitpos;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_fill_addr = r_fill_addr;
        n_res_data  = r_res_data;
        n_res_drop  = r_res_drop;
        o_pop       = 1'b0;
        out_load    = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_cmd.addr[AW-1:0];
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;
        ram_raddr   = i_cmd.addr[AW-1:0];
        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop      = 1'b1;
                    n_cmd      = i_cmd;
                    n_res_data = '0;
                    n_res_drop = 1'b0;
                    case (i_cmd.kind)
                        K_DRAW, K_READ: begin
                            ram_re  = 1'b1;
                            n_state = B_MOD;
                        end
                        K_FILL: begin
                            n_fill_addr = '0;
                            n_state     = B_FILL;
                        end
                        K_DROP: begin
                            n_res_drop = 1'b1;
                            n_state    = B_DONE;
                        end
                        default: n_state = B_DONE;
                    endcase
                end
            end
            B_MOD: begin
                if (r_cmd.kind == K_DRAW) begin
                    ram_we    = 1'b1;
                    ram_wdata = r_cmd.white ? (ram_rdata & ~bit_mask)
                                            : (ram_rdata | bit_mask);
                end else begin
                    n_res_data = ram_rdata;
                end
                n_state = B_DONE;
            end
            B_FILL: begin
                ram_we      = 1'b1;
                ram_waddr   = r_fill_addr;
                ram_wdata   = r_cmd.white ? BYTE_WHITE : BYTE_BLACK;
                n_fill_addr = r_fill_addr + AW'(1);
                if (r_fill_addr == LAST_ADDR) begin
                    n_state = B_DONE;
                end
            end
            B_DONE: begin
                if (!r_ovalid || o_rsp.ready) begin
                    out_load = 1'b1;
                    n_state  = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (r_ovalid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end
        if (out_load) begin
            n_ovalid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_fill_addr <= n_fill_addr;
        r_res_data  <= n_res_data;
        r_res_drop  <= n_res_drop;
        if (out_load) begin
            r_odata <= r_res_data;
            r_odrop <= r_res_drop;
        end
    end

    assign o_rsp.valid     = r_ovalid;
    assign o_rsp.read_data = r_odata;
    assign o_rsp.dropped   = r_odrop;
endmodule

>>> hdl/rotated_mono_framebuffer_top.sv
// Top level of the rotated monochrome frame store: APB rotation register,
// front part, command queue and back part. Depends on rmfb_pkg, the channel
// interfaces, rmfb_front, rmfb_fifo and rmfb_back.
//
//   Channel   Direction  Handshake          Payload
//   i_req     in         valid/ready        req_type, pixel_x, pixel_y, pixel_white, byte_index
//   o_rsp     out        valid/ready        read_data, dropped
//   APB       in         psel/penable       rotation at byte addresses 0 to 3
//
// The front part checks and rotates a request as it takes it, then forms the byte address with
// the row multiply and pushes it, taking no new request until the push, which waits while the
// queue is full. The back part does memory read, write back and result for a draw or a read,
// only the result for a dropped or unused request. A fill sweeps memory one address per cycle.
// Reset is synchronous and clears control state only; the store holds garbage until filled.
// A stalled result sits in the output register; the two-entry queue takes requests until full.
module rotated_mono_framebuffer_top import rmfb_pkg::*; #(
    parameter int PANEL_WIDTH  = 800,
    parameter int PANEL_HEIGHT = 480
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rmfb_req_if.sink    i_req,
    rmfb_rsp_if.source  o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [1:0] r_rotation;
    logic       reg_hit;
    logic       fifo_push;
    logic       fifo_pop;
    logic       fifo_full;
    logic       fifo_empty;
    t_cmd       front_cmd;
    t_cmd       head_cmd;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == 1'b0);
    assign prdata  = reg_hit ? {30'd0, r_rotation} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotation <= ROT_0;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_rotation <= pwdata[1:0];
        end
    end

    rmfb_front #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_rotation (r_rotation),
        .i_full     (fifo_full),
        .o_push     (fifo_push),
        .o_cmd      (front_cmd)
    );

    rmfb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fifo_push),
        .i_cmd   (front_cmd),
        .o_full  (fifo_full),
        .i_pop   (fifo_pop),
        .o_empty (fifo_empty),
        .o_cmd   (head_cmd)
    );

    rmfb_back #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (fifo_empty),
        .i_cmd   (head_cmd),
        .o_pop   (fifo_pop),
        .o_rsp   (o_rsp)
    );
endmodule

>>> hdl/rmfb_checker.sv
// Port-level checker for the rotated monochrome frame store, bound to the top level.
// Depends only on the top level's ports.
module rmfb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [7:0]  i_rsp_data,
    input logic        i_rsp_dropped,
    input logic        i_psel,
    input logic        i_penable,
    input logic        i_pwrite,
    input logic [2:0]  i_paddr,
    input logic [31:0] i_pwdata,
    input logic [31:0] i_prdata
);
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_data)
                                           && $stable(i_rsp_dropped)))
        else $error("Result changed or vanished while stalled.");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("Result valid right after reset.");

    a_drop_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_dropped) |-> (i_rsp_data == 8'd0))
        else $error("Dropped draw carries read data.");

    a_rot_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_psel && i_penable && i_pwrite && !i_paddr[2])
        |=> (i_paddr[2] || (i_prdata == {30'd0, $past(i_pwdata[1:0])})))
        else $error("Rotation register does not read back the written value.");
endmodule

bind rotated_mono_framebuffer_top rmfb_checker u_rmfb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_data    (o_rsp.read_data),
    .i_rsp_dropped (o_rsp.dropped),
    .i_psel        (psel),
    .i_penable     (penable),
    .i_pwrite      (pwrite),
    .i_paddr       (paddr),
    .i_pwdata      (pwdata),
    .i_prdata      (prdata)
);
